/* sv/ccc_pkg.sv */
package ccc_pkg;
	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;
	localparam logic [7:0] THRESH_RST = 8'd125;
	localparam logic [7:0] PIX_LIGHT  = 8'd255;
	localparam logic [7:0] PIX_DARK   = 8'd0;
	localparam int TALLY_W = 11;
	localparam logic [TALLY_W-1:0] TALLY_MAX = 11'd2047;

	localparam logic [1:0] REG_THRESH = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_LOAD,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_POP_RD,
		ST_POP_CHK,
		ST_NB_RD,
		ST_NB_CHK,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;    // write zero to visited at clear counter, advance
		logic load;        // write incoming pixel, advance position
		logic scan_rd;     // read maps at scan pointer
		logic scan_next;   // advance scan pointer
		logic seed;        // mark scan pixel visited, push it, bump tally
		logic pop_rd;      // read queue at head
		logic pop_take;    // latch popped coordinate, start neighbor count
		logic nb_rd;       // read maps at current neighbor
		logic nb_push;     // mark neighbor visited and push it
		logic nb_next;     // advance neighbor index
		logic frame_end;   // reset position for next frame
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic last_pix;    // incoming pixel closes the frame
		logic scan_last;
		logic scan_hit;    // dark and not visited (scan pixel)
		logic q_empty;
		logic nb_valid;    // neighbor inside the frame
		logic nb_hit;      // dark and not visited (neighbor)
		logic nb_last;
	} stat_t;
endpackage

/* sv/ccc_ram.sv */
module ccc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/ccc_ctrl.sv */
module ccc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  ccc_pkg::stat_t  st,
	output ccc_pkg::cmd_t   cmd,
	output logic            res_load,
	output logic            res_done
);
	ccc_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;
	logic take;

	// A new request is taken only while loading and the result slot is free.
	assign take = (state_q == ccc_pkg::ST_LOAD) && in_valid && !(out_valid_q && out_stall);
	assign in_stall = !((state_q == ccc_pkg::ST_LOAD) && !(out_valid_q && out_stall));
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ccc_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccc_pkg::ST_CLEAR: if (st.clr_last) state_d = ccc_pkg::ST_LOAD;
			ccc_pkg::ST_LOAD: begin
				if (take && st.last_pix) state_d = ccc_pkg::ST_SCAN_RD;
			end
			ccc_pkg::ST_SCAN_RD:  state_d = ccc_pkg::ST_SCAN_CHK;
			ccc_pkg::ST_SCAN_CHK: begin
				if (st.scan_hit) state_d = ccc_pkg::ST_POP_RD;
				else if (st.scan_last) state_d = ccc_pkg::ST_OUT;
				else state_d = ccc_pkg::ST_SCAN_RD;
			end
			ccc_pkg::ST_POP_RD: begin
				if (st.q_empty) begin
					state_d = st.scan_last ? ccc_pkg::ST_OUT : ccc_pkg::ST_SCAN_RD;
				end else begin
					state_d = ccc_pkg::ST_POP_CHK;
				end
			end
			ccc_pkg::ST_POP_CHK: state_d = ccc_pkg::ST_NB_RD;
			ccc_pkg::ST_NB_RD: begin
				if (!st.nb_valid) begin
					state_d = st.nb_last ? ccc_pkg::ST_POP_RD : ccc_pkg::ST_NB_RD;
				end else begin
					state_d = ccc_pkg::ST_NB_CHK;
				end
			end
			ccc_pkg::ST_NB_CHK: begin
				state_d = st.nb_last ? ccc_pkg::ST_POP_RD : ccc_pkg::ST_NB_RD;
			end
			ccc_pkg::ST_OUT: begin
				if (!(out_valid_q && out_stall)) state_d = ccc_pkg::ST_CLEAR;
			end
			default: state_d = ccc_pkg::ST_CLEAR;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd         = '0;
		res_load    = 1'b0;
		res_done    = 1'b0;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			ccc_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			ccc_pkg::ST_LOAD: begin
				if (take) begin
					cmd.load = 1'b1;
					if (!st.last_pix) begin
						res_load    = 1'b1;
						out_valid_d = 1'b1;
					end
				end
			end
			ccc_pkg::ST_SCAN_RD: cmd.scan_rd = 1'b1;
			ccc_pkg::ST_SCAN_CHK: begin
				if (st.scan_hit) cmd.seed = 1'b1;
				else if (!st.scan_last) cmd.scan_next = 1'b1;
			end
			ccc_pkg::ST_POP_RD: begin
				if (st.q_empty) begin
					if (!st.scan_last) cmd.scan_next = 1'b1;
				end else begin
					cmd.pop_rd = 1'b1;
				end
			end
			ccc_pkg::ST_POP_CHK: cmd.pop_take = 1'b1;
			ccc_pkg::ST_NB_RD: begin
				if (st.nb_valid) cmd.nb_rd = 1'b1;
				else cmd.nb_next = 1'b1;
			end
			ccc_pkg::ST_NB_CHK: begin
				cmd.nb_next = 1'b1;
				if (st.nb_hit) cmd.nb_push = 1'b1;
			end
			ccc_pkg::ST_OUT: begin
				if (!(out_valid_q && out_stall)) begin
					cmd.frame_end = 1'b1;
					res_load      = 1'b1;
					res_done      = 1'b1;
					out_valid_d   = 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule

/* sv/ccc_datapath.sv */
module ccc_datapath #(
	parameter int MAX_WIDTH  = ccc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ccc_pkg::MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [7:0]                   cfg_data,
	input  logic [7:0]                   pixel_value,
	input  ccc_pkg::cmd_t                cmd,
	output ccc_pkg::stat_t               st,
	input  logic                         res_load,
	input  logic                         res_done,
	output logic [7:0]                   out_pixel,
	output logic [ccc_pkg::TALLY_W-1:0]  region_count,
	output logic                         frame_done
);
	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PW    = AW + 1;
	localparam int QW    = RW + CW;
	localparam int SW    = CW + RW + 2;
	localparam int TW    = ccc_pkg::TALLY_W;

	logic [7:0] thresh_q;
	logic [6:0] fw_q, fh_q;
	logic [CW:0] w_c;
	logic [RW:0] h_c;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ccc_pkg::THRESH_RST;
			fw_q     <= 7'd64;
			fh_q     <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ccc_pkg::REG_THRESH: thresh_q <= cfg_data;
				ccc_pkg::REG_WIDTH:  fw_q     <= cfg_data[6:0];
				ccc_pkg::REG_HEIGHT: fh_q     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Clamp frame size to 1..MAX.
	always_comb begin
		if (fw_q == 7'd0) w_c = (CW+1)'(1);
		else if (32'(fw_q) > MAX_WIDTH) w_c = (CW+1)'(MAX_WIDTH);
		else w_c = (CW+1)'(fw_q);
		if (fh_q == 7'd0) h_c = (RW+1)'(1);
		else if (32'(fh_q) > MAX_HEIGHT) h_c = (RW+1)'(MAX_HEIGHT);
		else h_c = (RW+1)'(fh_q);
	end

	// Load position in raster order; the frame ends once it reaches the current area.
	logic [AW-1:0] lpos_q;
	logic          ldark;
	logic          l_endfrm;
	logic [SW-1:0] area_c;
	assign ldark    = pixel_value < thresh_q;
	assign area_c   = SW'(w_c) * SW'(h_c);
	assign l_endfrm = (SW'(lpos_q) + SW'(1)) >= area_c;

	// Map address of a pixel for a frame of the given width.
	function automatic logic [AW-1:0] addr_of(input logic [RW:0] r, input logic [CW:0] c,
		input logic [CW:0] w);
		logic [SW:0] a;
		a = (SW+1)'(r) * (SW+1)'(w) + (SW+1)'(c);
		return a[AW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpos_q <= '0;
		end else if (cmd.frame_end) begin
			lpos_q <= '0;
		end else if (cmd.load && !l_endfrm) begin
			lpos_q <= lpos_q + AW'(1);
		end
	end

	// Frame size is latched at the end of loading for the count.
	logic [CW:0] fw_s_q;
	logic [RW:0] fh_s_q;
	always_ff @(posedge clk) begin
		if (cmd.load && l_endfrm) begin
			fw_s_q <= w_c;
			fh_s_q <= h_c;
		end
	end

	// Visited map clear sweep.
	logic [PW-1:0] clr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_step) clr_q <= st.clr_last ? '0 : clr_q + PW'(1);
	end

	// Scan pointer and current popped/neighbor coordinates.
	logic [RW:0] srow_q, prow_q;
	logic [CW:0] scol_q, pcol_q;
	logic [3:0]  nb_q;
	logic [1:0]  nb_dr, nb_dc;
	logic [RW+1:0] nrow;
	logic [CW+1:0] ncol;
	logic [RW:0] nrow_q;
	logic [CW:0] ncol_q;
	logic        s_endrow;
	assign s_endrow = (scol_q + (CW+1)'(1)) >= fw_s_q;

	// Neighbor index 0..8 walks the 3x3 window row by row.
	always_comb begin
		case (nb_q)
			4'd0, 4'd1, 4'd2: nb_dr = 2'd0;
			4'd3, 4'd4, 4'd5: nb_dr = 2'd1;
			default:          nb_dr = 2'd2;
		endcase
		case (nb_q)
			4'd0, 4'd3, 4'd6: nb_dc = 2'd0;
			4'd1, 4'd4, 4'd7: nb_dc = 2'd1;
			default:          nb_dc = 2'd2;
		endcase
		nrow = (RW+2)'(prow_q) + (RW+2)'(nb_dr) - (RW+2)'(1);
		ncol = (CW+2)'(pcol_q) + (CW+2)'(nb_dc) - (CW+2)'(1);
	end

	// Queue head and tail; entries hold row and column side by side.
	logic [PW-1:0] qh_q, qt_q;
	logic [QW-1:0] qd;
	logic [RW:0]   qrow;
	logic [CW:0]   qcol;
	assign qrow = {1'b0, qd[QW-1:CW]};
	assign qcol = {1'b0, qd[CW-1:0]};

	// Map port mux.
	logic [AW-1:0] m_raddr, m_waddr;
	logic          dk_we, dk_rd, vs_we, vs_wd, vs_rd;
	logic          q_we;
	logic [QW-1:0] q_wd;

	always_comb begin
		m_raddr = '0;
		if (cmd.scan_rd) m_raddr = addr_of(srow_q, scol_q, fw_s_q);
		if (cmd.nb_rd) m_raddr = addr_of(nrow[RW:0], ncol[CW:0], fw_s_q);
		dk_we = cmd.load;
		vs_we = 1'b0;
		vs_wd = 1'b1;
		m_waddr = lpos_q;
		q_we = 1'b0;
		q_wd = {srow_q[RW-1:0], scol_q[CW-1:0]};
		if (cmd.clr_step) begin
			vs_we = 1'b1;
			vs_wd = 1'b0;
			m_waddr = clr_q[AW-1:0];
		end else if (cmd.seed) begin
			vs_we = 1'b1;
			q_we = 1'b1;
			m_waddr = addr_of(srow_q, scol_q, fw_s_q);
		end else if (cmd.nb_push) begin
			vs_we = 1'b1;
			q_we = 1'b1;
			m_waddr = addr_of(nrow_q, ncol_q, fw_s_q);
			q_wd = {nrow_q[RW-1:0], ncol_q[CW-1:0]};
		end
	end

	ccc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_dark (
		.clk(clk), .we(dk_we), .waddr(m_waddr), .wdata(ldark),
		.raddr(m_raddr), .rdata(dk_rd)
	);
	ccc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis (
		.clk(clk), .we(vs_we), .waddr(m_waddr), .wdata(vs_wd),
		.raddr(m_raddr), .rdata(vs_rd)
	);
	ccc_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
		.clk(clk), .we(q_we), .waddr(qt_q[AW-1:0]), .wdata(q_wd),
		.raddr(qh_q[AW-1:0]), .rdata(qd)
	);

	// Scan, queue and neighbor sequencing; each dark pixel enters the queue once per frame.
	logic [ccc_pkg::TALLY_W-1:0] tally_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srow_q <= '0; scol_q <= '0; qh_q <= '0; qt_q <= '0;
			nb_q <= '0; tally_q <= '0;
		end else begin
			if (cmd.frame_end) begin
				srow_q <= '0; scol_q <= '0; tally_q <= '0;
				qh_q <= '0; qt_q <= '0;
			end else if (cmd.scan_next) begin
				if (s_endrow) begin
					scol_q <= '0;
					srow_q <= srow_q + (RW+1)'(1);
				end else begin
					scol_q <= scol_q + (CW+1)'(1);
				end
			end
			if (cmd.seed) begin
				qt_q <= qt_q + PW'(1);
				if (tally_q != ccc_pkg::TALLY_MAX) tally_q <= tally_q + TW'(1);
			end
			if (cmd.pop_rd) qh_q <= qh_q + PW'(1);
			if (cmd.nb_push) qt_q <= qt_q + PW'(1);
			if (cmd.pop_take) nb_q <= '0;
			else if (cmd.nb_next) nb_q <= nb_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_take) begin
			prow_q <= qrow;
			pcol_q <= qcol;
		end
		if (cmd.nb_rd) begin
			nrow_q <= nrow[RW:0];
			ncol_q <= ncol[CW:0];
		end
	end

	// Status.
	always_comb begin
		st.clr_last  = clr_q == PW'(CELLS - 1);
		st.last_pix  = l_endfrm;
		st.scan_last = s_endrow && ((srow_q + (RW+1)'(1)) >= fh_s_q);
		st.scan_hit  = dk_rd && !vs_rd;
		st.q_empty   = qh_q == qt_q;
		st.nb_valid  = !nrow[RW+1] && !ncol[CW+1] &&
			(nrow[RW:0] < fh_s_q) && (ncol[CW:0] < fw_s_q);
		st.nb_hit    = dk_rd && !vs_rd;
		st.nb_last   = nb_q == 4'd8;
	end

	// Result register; the last pixel's value is held until the count is done.
	logic last_dark_q;
	always_ff @(posedge clk) begin
		if (cmd.load) last_dark_q <= ldark;
		if (res_load) begin
			out_pixel    <= (res_done ? last_dark_q : ldark) ? ccc_pkg::PIX_DARK
			                                                 : ccc_pkg::PIX_LIGHT;
			region_count <= res_done ? tally_q : '0;
			frame_done   <= res_done;
		end
	end
endmodule

/* sv/connected_component_counter.sv */
// Channel  | valid        | stall         | payload
// input    | in_valid     | in_stall      | pixel_value
// output   | out_valid    | out_stall     | out_pixel, region_count, frame_done
// config   | cfg_we       | -             | cfg_index, cfg_data
//
// Loading takes one pixel per cycle while no result is stalled; each result but the
// last is registered and leaves in the cycle after its pixel. After the last pixel
// the count runs: each scanned pixel is read and then checked, and each region pixel
// takes a queue pop plus a read and check per neighbor probe inside the frame, bound
// by the single map read port. After reset and after each frame, a clear pass over all
// MAX_WIDTH*MAX_HEIGHT entries wipes the visited map; no request is taken meanwhile.
// A stalled result holds; input is stalled while it is pending.
module connected_component_counter #(
	parameter int MAX_WIDTH  = ccc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ccc_pkg::MAX_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [7:0]                  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  pixel_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_pixel,
	output logic [ccc_pkg::TALLY_W-1:0] region_count,
	output logic                        frame_done
);
	ccc_pkg::cmd_t  cmd;
	ccc_pkg::stat_t st;
	logic res_load, res_done;

	ccc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd),
		.res_load(res_load), .res_done(res_done)
	);

	ccc_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pixel_value(pixel_value), .cmd(cmd), .st(st),
		.res_load(res_load), .res_done(res_done), .out_pixel(out_pixel),
		.region_count(region_count), .frame_done(frame_done)
	);

	// A result is never overwritten while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_pixel))
		else $error("result changed while stalled");

	// A count is only reported on a frame end.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> region_count == '0)
		else $error("count on non-final result");

	// Loads never happen together with a push.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && (cmd.seed || cmd.nb_push)))
		else $error("map write conflict");
endmodule

/* tb/connected_component_counter_tb.sv */
`timescale 1ns / 100ps

module connected_component_counter_tb;
	localparam int CELLS = ccc_pkg::MAX_WIDTH_DEF * ccc_pkg::MAX_HEIGHT_DEF;
	localparam int DRAIN_CYCLES = 3 * CELLS;

	typedef struct {
		logic [7:0]                  pix;
		logic [ccc_pkg::TALLY_W-1:0] count;
		logic                        done;
	} pixel_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = ccc_pkg::REG_THRESH;
	logic [7:0]         cfg_data = 8'd0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         pixel_value = 8'd0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         out_pixel;
	logic [ccc_pkg::TALLY_W-1:0] region_count;
	logic               frame_done;

	// Mirror of the configuration and of the frame state.
	logic [7:0]    thr_q = ccc_pkg::THRESH_RST;
	logic [6:0]    width_q = 7'd64;
	logic [6:0]    height_q = 7'd64;
	bit            dark_bits [CELLS];
	bit            seen [CELLS];
	int            bfs_fifo [CELLS];
	int            pix_pos = 0;

	logic [7:0]    pixel_queue [$];
	pixel_result_t result_queue [$];
	int            errors = 0;
	int            snd_idle_pct = 14;
	int            rcv_idle_pct = 73;
	logic          hold_go = 1'b0;
	int            hold_left = 0;

	connected_component_counter DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel_value(pixel_value),
		.out_valid(out_valid), .out_stall(out_stall), .out_pixel(out_pixel),
		.region_count(region_count), .frame_done(frame_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_dim(input logic [6:0] v, input int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// Count 8-connected dark regions with a breadth-first fill.
	function automatic int count_dark_regions(input int w, input int h);
		int n, head, tail, p, r, c, nr, nc, q, tally;
		n = w * h;
		tally = 0;
		for (p = 0; p < n && p < CELLS; p++) begin
			if (dark_bits[p] && !seen[p]) begin
				head = 0;
				tail = 0;
				seen[p] = 1;
				bfs_fifo[tail++] = p;
				while (head < tail) begin
					r = bfs_fifo[head] / w;
					c = bfs_fifo[head] % w;
					head++;
					for (nr = r - 1; nr <= r + 1; nr++)
						for (nc = c - 1; nc <= c + 1; nc++) begin
							if (nr < 0 || nc < 0 || nr >= h || nc >= w) continue;
							q = nr * w + nc;
							if (q < CELLS && dark_bits[q] && !seen[q]) begin
								seen[q] = 1;
								bfs_fifo[tail++] = q;
							end
						end
				end
				if (tally < ccc_pkg::TALLY_MAX) tally++;
			end
		end
		return tally;
	endfunction

	// Work out the result of one accepted pixel.
	task automatic predict_pixel(input logic [7:0] v);
		int w, h;
		bit dark;
		pixel_result_t res;
		w = clamp_dim(width_q, ccc_pkg::MAX_WIDTH_DEF);
		h = clamp_dim(height_q, ccc_pkg::MAX_HEIGHT_DEF);
		dark = v < thr_q;
		if (pix_pos == 0) foreach (seen[i]) seen[i] = 0;
		if (pix_pos < CELLS) dark_bits[pix_pos] = dark;
		res.pix = dark ? ccc_pkg::PIX_DARK : ccc_pkg::PIX_LIGHT;
		if (pix_pos + 1 >= w * h || pix_pos + 1 >= CELLS) begin
			res.count = count_dark_regions(w, h);
			res.done = 1'b1;
			pix_pos = 0;
		end else begin
			res.count = '0;
			res.done = 1'b0;
			pix_pos++;
		end
		result_queue.push_back(res);
	endtask

	// Driver: offer pending pixels, hold a request while it is stalled.
	always @(posedge clk) begin
		if (in_valid && !in_stall) predict_pixel(pixel_value);
		if (!in_valid || !in_stall) begin
			if (pixel_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				in_valid <= 1'b1;
				pixel_value <= pixel_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted here.
	always @(posedge clk) begin
		if (hold_left != 0) hold_left <= hold_left - 1;
		else if (hold_go) hold_left <= 600;
	end

	// Monitor: check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		pixel_result_t exp_res;
		if (out_valid && !out_stall) begin
			if (result_queue.size() == 0) begin
				$error("unexpected result: out_pixel %0d", out_pixel);
				errors++;
			end else begin
				exp_res = result_queue.pop_front();
				if (out_pixel !== exp_res.pix) begin
					$error("out_pixel: expected %0d, actual %0d", exp_res.pix, out_pixel);
					errors++;
				end
				if (region_count !== exp_res.count) begin
					$error("region_count: expected %0d, actual %0d",
						exp_res.count, region_count);
					errors++;
				end
				if (frame_done !== exp_res.done) begin
					$error("frame_done: expected %0d, actual %0d", exp_res.done, frame_done);
					errors++;
				end
			end
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_idle_pct);
	end

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ccc_pkg::REG_THRESH: thr_q = data;
			ccc_pkg::REG_WIDTH:  width_q = data[6:0];
			ccc_pkg::REG_HEIGHT: height_q = data[6:0];
			default: ;
		endcase
	endtask

	// Wait until the block has delivered everything and finished its clear pass.
	task automatic wait_idle();
		wait (pixel_queue.size() == 0 && result_queue.size() == 0 && !in_valid);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] gen_pixel();
		case ($urandom_range(3))
			0: return $urandom_range(255);
			1: return (thr_q == 0) ? 8'd0 : 8'($urandom_range(thr_q - 1));
			default: return 8'($urandom_range(255, thr_q));
		endcase
	endfunction

	task automatic set_frame(input logic [7:0] thr, input logic [7:0] w, input logic [7:0] h);
		wait_idle();
		write_reg(ccc_pkg::REG_THRESH, thr);
		write_reg(ccc_pkg::REG_WIDTH, w);
		write_reg(ccc_pkg::REG_HEIGHT, h);
	endtask

	task automatic push_frame(input int n);
		repeat (n) pixel_queue.push_back(gen_pixel());
	endtask

	initial begin
		int sent, w, h, n;
		bit held;
		held = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: threshold boundaries in a 3x3 frame.
		set_frame(ccc_pkg::THRESH_RST, 8'd3, 8'd3);
		pixel_queue = '{8'd0, 8'd255, 8'd124, 8'd125, 8'd126, 8'd0, 8'd255, 8'd124, 8'd0};
		// A single dark pixel, then a single light pixel.
		set_frame(8'd100, 8'd1, 8'd1);
		pixel_queue.push_back(8'd99);
		pixel_queue.push_back(8'd100);
		// Width zero acts as one; the top bit of the data is dropped.
		set_frame(8'd255, 8'd0, 8'd130);
		pixel_queue = '{8'd254, 8'd255};
		// Threshold zero: nothing is dark.
		set_frame(8'd0, 8'd2, 8'd2);
		pixel_queue = '{8'd0, 8'd0, 8'd0, 8'd255};
		// Size shrinks mid-frame past the current position.
		set_frame(8'd128, 8'd4, 8'd4);
		pixel_queue = '{8'd1, 8'd200, 8'd1, 8'd200, 8'd1, 8'd200};
		set_frame(8'd128, 8'd2, 8'd2);
		pixel_queue = '{8'd5, 8'd5};
		// Widest and tallest frames.
		set_frame(8'd128, 8'd64, 8'd1);
		push_frame(64);
		set_frame(8'd128, 8'd1, 8'd64);
		push_frame(64);

		// Random frames, mostly small and complete, sometimes cut short.
		sent = 0;
		while (sent < 1800) begin
			if (sent >= 600 && sent < 1200) begin
				snd_idle_pct = 73;
				rcv_idle_pct = 14;
			end else if (sent >= 1200) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			case ($urandom_range(9))
				0: begin w = 64; h = $urandom_range(1, 2); end
				1: begin w = $urandom_range(1, 2); h = 64; end
				default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 8); end
			endcase
			set_frame($urandom_range(9) == 0 ? 8'($urandom_range(1) * 255) : 8'($urandom_range(255)),
				8'(w | ($urandom_range(1) << 7)), 8'(h | ($urandom_range(1) << 7)));
			n = w * h;
			if ($urandom_range(7) == 0) n = $urandom_range(0, n);
			push_frame(n);
			// Hold the receiver off once while this frame is being offered.
			if (!held && sent >= 300 && n > 0) begin
				held = 1'b1;
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			sent += n;
		end
		// Close any frame left open.
		set_frame(8'd128, 8'd1, 8'd1);
		push_frame(1);

		wait (pixel_queue.size() == 0 && result_queue.size() == 0 && !in_valid);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

/* files.f */
sv/ccc_pkg.sv
sv/ccc_ram.sv
sv/ccc_ctrl.sv
sv/ccc_datapath.sv
sv/connected_component_counter.sv
tb/connected_component_counter_tb.sv
